>>> src/perm_unrk_pkg.sv
// Package for the permutation unranking block.
// Holds the shared constants, the factorial table and the controller/datapath structs.
// Used by perm_unrk_ctrl, perm_unrk_dp and permutation_unrank_top.
package perm_unrk_pkg;

  localparam int unsigned MaxElements = 12;
  localparam int unsigned CountW      = 4;
  localparam int unsigned RankW       = 29;
  localparam int unsigned FactW       = 32;
  localparam int unsigned AddrW       = 3;

  localparam logic [CountW-1:0] CountReset = 4'd12;
  localparam logic              RegElementCount = 1'b0;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       div_step;
    logic       emit_err;
    logic       emit_digit;
    logic [1:0] step;
  } pu_cmd_t;

  typedef struct packed {
    logic too_big;
    logic out_free;
    logic last_digit;
  } pu_status_t;

  function automatic logic [FactW-1:0] fact(input logic [CountW-1:0] idx);
    logic [FactW-1:0] f;
    case (idx)
      4'd0:    f = 32'd1;
      4'd1:    f = 32'd1;
      4'd2:    f = 32'd2;
      4'd3:    f = 32'd6;
      4'd4:    f = 32'd24;
      4'd5:    f = 32'd120;
      4'd6:    f = 32'd720;
      4'd7:    f = 32'd5040;
      4'd8:    f = 32'd40320;
      4'd9:    f = 32'd362880;
      4'd10:   f = 32'd3628800;
      4'd11:   f = 32'd39916800;
      4'd12:   f = 32'd479001600;
      default: f = 32'hFFFF_FFFF;
    endcase
    return f;
  endfunction

  function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] raw);
    logic [CountW-1:0] n;
    n = raw;
    if (n == '0) n = 4'd1;
    if (n > CountW'(MaxElements)) n = CountW'(MaxElements);
    return n;
  endfunction

endpackage

>>> src/perm_unrk_ctrl.sv
// Controller state machine of the permutation unranking block.
// Sequences the range check, the four-step digit division and the result handoff.
// Depends on perm_unrk_pkg for the command and status structs.
module perm_unrk_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  perm_unrk_pkg::pu_status_t status_i,
  output perm_unrk_pkg::pu_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (status_i.too_big) begin
          if (status_i.out_free) begin
            cmd_o.emit_err = 1'b1;
            state_d        = StIdle;
          end
        end else begin
          cmd_o.start = 1'b1;
          step_d      = 2'd3;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        if (step_q != 2'd0) begin
          cmd_o.div_step = 1'b1;
          step_d         = step_q - 2'd1;
        end else if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          step_d           = 2'd3;
          if (status_i.last_digit) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= 2'd3;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_digit |-> (state_q == StDiv) && (step_q == 2'd0))
    else $error("Digit emitted before the division finished.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_digit || cmd_o.emit_err) |-> status_i.out_free)
    else $error("Result written while the output register is occupied.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StCheck))
    else $error("Accepted item did not enter the range check.");

endmodule

>>> src/perm_unrk_dp.sv
// Datapath of the permutation unranking block.
// Holds the rank, remainder, digit counter, element pool and the result register.
// Depends on perm_unrk_pkg for the factorial table and the command and status structs.
module perm_unrk_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [3:0]                count_i,
  input  logic [28:0]               rank_i,
  input  perm_unrk_pkg::pu_cmd_t    cmd_i,
  output perm_unrk_pkg::pu_status_t status_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [3:0]                element_o,
  output logic [3:0]                position_o,
  output logic                      last_o,
  output logic                      error_o
);

  localparam int unsigned Cw = perm_unrk_pkg::CountW;
  localparam int unsigned Rw = perm_unrk_pkg::RankW;
  localparam int unsigned Fw = perm_unrk_pkg::FactW;
  localparam int unsigned Me = perm_unrk_pkg::MaxElements;

  logic [Rw-1:0] rank_q;
  logic [Rw-1:0] rem_q;
  logic [Cw-1:0] n_q;
  logic [Cw-1:0] digit_idx_q;
  logic [3:0]    quot_q;
  logic [Cw-1:0] pool_q [Me];

  logic          out_valid_q;
  logic [3:0]    element_q;
  logic [3:0]    position_q;
  logic          last_q;
  logic          error_q;

  logic [Fw-1:0] f_cur;
  logic [Fw-1:0] f_sh;
  logic [Fw-1:0] rem_ext;
  logic [Fw-1:0] rem_sub;
  logic          ge;
  logic [Rw-1:0] rem_next;
  logic [Cw-1:0] pool_len;
  logic [3:0]    raw_dig;
  logic [Cw-1:0] dig;
  logic          last_digit;

  always_comb begin
    f_cur    = perm_unrk_pkg::fact(n_q - Cw'(1) - digit_idx_q);
    f_sh     = f_cur << cmd_i.step;
    rem_ext  = {{(Fw-Rw){1'b0}}, rem_q};
    ge       = rem_ext >= f_sh;
    rem_sub  = rem_ext - f_sh;
    rem_next = ge ? rem_sub[Rw-1:0] : rem_q;
    pool_len = n_q - digit_idx_q;
    raw_dig  = {quot_q[3:1], ge};
    dig      = (raw_dig >= pool_len) ? pool_len - Cw'(1) : raw_dig;
    last_digit = (digit_idx_q == n_q - Cw'(1));
  end

  assign status_o.too_big    = {{(Fw-Rw){1'b0}}, rank_q} >= perm_unrk_pkg::fact(n_q);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.last_digit = last_digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      digit_idx_q <= '0;
      n_q         <= perm_unrk_pkg::CountReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        n_q <= perm_unrk_pkg::eff_count(count_i);
      end
      if (cmd_i.start) begin
        rem_q       <= rank_q;
        digit_idx_q <= '0;
      end else if (cmd_i.div_step) begin
        rem_q <= rem_next;
      end else if (cmd_i.emit_digit) begin
        rem_q       <= rem_next;
        digit_idx_q <= digit_idx_q + Cw'(1);
      end
      if (cmd_i.emit_err || cmd_i.emit_digit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rank_q <= rank_i;
    end
    if (cmd_i.div_step) begin
      quot_q[cmd_i.step] <= ge;
    end
    if (cmd_i.start) begin
      for (int k = 0; k < Me; k++) begin
        pool_q[k] <= Cw'(k);
      end
    end else if (cmd_i.emit_digit) begin
      for (int j = 0; j < Me - 1; j++) begin
        if (Cw'(j) >= dig) pool_q[j] <= pool_q[j+1];
      end
    end
    if (cmd_i.emit_err) begin
      element_q  <= '0;
      position_q <= '0;
      last_q     <= 1'b1;
      error_q    <= 1'b1;
    end else if (cmd_i.emit_digit) begin
      element_q  <= pool_q[dig];
      position_q <= digit_idx_q;
      last_q     <= last_digit;
      error_q    <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = element_q;
  assign position_o  = position_q;
  assign last_o      = last_q;
  assign error_o     = error_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_digit |-> (raw_dig < pool_len))
    else $error("Lehmer digit exceeds the remaining pool.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_digit |-> ({{(Fw-Rw){1'b0}}, rem_next} < f_cur))
    else $error("Remainder not reduced below the factorial weight.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_idx_q <= Cw'(Me)))
    else $error("Digit counter ran past the largest element count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && error_q) |-> (last_q && (element_q == '0)))
    else $error("Error result is not a single final result.");

endmodule

>>> src/permutation_unrank_top.sv
// A rank is accepted only while idle, once the last result of the previous rank is written.
// The range check comes first: an out-of-range rank gives one error result, a rank in range
// gives one element per factorial-base digit, each found by a four-step restoring division.
// A result waits while the output register is occupied.
// Reset is asynchronous and active low; the element count returns to twelve.
// Top level: APB register, controller and datapath. Depends on perm_unrk_pkg.
module permutation_unrank_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [perm_unrk_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [28:0]                      rank_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [3:0]                       element_o,
  output logic [3:0]                       position_o,
  output logic                             last_o,
  output logic                             error_o
);

  logic [3:0]                count_q;
  perm_unrk_pkg::pu_cmd_t    cmd;
  perm_unrk_pkg::pu_status_t status;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == perm_unrk_pkg::RegElementCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= perm_unrk_pkg::CountReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      count_q <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) prdata = {28'd0, count_q};
  end

  perm_unrk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  perm_unrk_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count_q),
    .rank_i      (rank_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .element_o   (element_o),
    .position_o  (position_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule
